[design/ray_box_nearest_hit_assert.svh]
// ============================================================================
// ray_box_nearest_hit assertion macros
// Shared concurrent assertion forms, clocked on aclk, held off during reset.
// ============================================================================
`ifndef RAY_BOX_NEAREST_HIT_ASSERT_SVH
`define RAY_BOX_NEAREST_HIT_ASSERT_SVH

// Same-cycle implication.
`define RBNH_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RBNH_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/rbnh_pkg.sv]
// ============================================================================
// rbnh_pkg
// Types, codes and constants shared by the nearest box hit modules.
// ============================================================================
package rbnh_pkg;

    localparam int RBNH_MAX_BOXES = 64;
    localparam int RBNH_FRAC_BITS = 16;

    // Far limit of a parallel axis and cutoff for a hit, in whole units.
    localparam int RBNH_SLAB_FAR_UNITS = 10000;
    localparam int RBNH_MISS_UNITS     = 10000000;

    localparam logic RBNH_OP_LOAD  = 1'b0;
    localparam logic RBNH_OP_QUERY = 1'b1;

    typedef enum logic [1:0] {
        EDGE_TOP,
        EDGE_BOTTOM,
        EDGE_LEFT,
        EDGE_RIGHT
    } rbnh_edge_t;

    typedef enum logic {
        ALU_DIV,
        ALU_MUL
    } rbnh_alu_mode_t;

    typedef struct packed {
        logic           start;
        rbnh_alu_mode_t mode;
    } rbnh_alu_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } rbnh_alu_sts_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_WAIT,
        ST_STEP,
        ST_DIV,
        ST_ORDER,
        ST_TEST,
        ST_BEST,
        ST_WRAP,
        ST_MULX_GO,
        ST_MULX,
        ST_MULY_GO,
        ST_MULY,
        ST_OUT
    } rbnh_state_t;

endpackage

[design/ray_box_nearest_hit.sv]
// ============================================================================
// ray_box_nearest_hit
// Slab test of a ray against a table of boxes, returning the nearest hit.
// ============================================================================
//
//  Channel | Direction | Carries
//  --------+-----------+------------------------------------------------------
//  s_      | in        | load item (one box) or query item (ray origin, target)
//  m_      | out       | one result item per query: hit, time, hit point
//  cfg_    | in        | active_boxes register write
//
//  A load item writes one box to the table. A query runs the slab test on each
//  of the n active boxes in turn through the single serial divide and multiply
//  unit, one quotient or multiplier bit per cycle; times are Q16.16 at the
//  default FRAC_BITS. A new query item is taken only after the last result is
//  accepted. Each edge of an axis parallel to the ray skips its divide, and a
//  miss skips the two multiplies.
//  s_tready is high only when no query is in progress and no result waits.
//  Reset is synchronous and clears control state; the box table is not cleared.
//
module ray_box_nearest_hit import rbnh_pkg::*; #(
    parameter int MAX_BOXES = RBNH_MAX_BOXES,
    parameter int FRAC_BITS = RBNH_FRAC_BITS
) (
    input  logic         aclk,
    input  logic         aresetn,
    // Input items.
    input  logic         s_tvalid,
    output logic         s_tready,
    // box_index[5:0], box_left[37:6], box_top[69:38], box_right[101:70],
    // box_bottom[133:102], ray_origin_x[165:134], ray_origin_y[197:166],
    // ray_target_x[229:198], ray_target_y[261:230], zero padding [263:262]
    input  logic [263:0] s_tdata,
    // op[0]
    input  logic [0:0]   s_tuser,
    // Result items.
    output logic         m_tvalid,
    input  logic         m_tready,
    // hit_time[31:0], hit_x[63:32], hit_y[95:64]
    output logic [95:0]  m_tdata,
    // hit[0]
    output logic [0:0]   m_tuser,
    // Configuration.
    input  logic         cfg_we,
    input  logic [6:0]   cfg_wdata
);

`include "ray_box_nearest_hit_assert.svh"

    // Widths that follow from the fraction size and the table depth.
    localparam int N_W  = 33 + FRAC_BITS;          // divide and time magnitude
    localparam int TW   = N_W + 1;                 // signed time
    localparam int PW   = 34 + N_W;                // full product
    localparam int IW   = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CW   = $clog2(MAX_BOXES + 1);
    localparam int CMPW = (CW > 7) ? CW : 7;

    localparam logic signed [TW-1:0] SLAB_FAR  = TW'(RBNH_SLAB_FAR_UNITS) << FRAC_BITS;
    localparam logic signed [TW-1:0] MISS_TIME = TW'(RBNH_MISS_UNITS) << FRAC_BITS;
    localparam logic signed [TW-1:0] T_I32_MAX = TW'(32'sh7fffffff);
    localparam logic signed [TW-1:0] T_I32_MIN = TW'($signed(32'h80000000));

    // ------------------------------------------------------------------
    // Input field view.
    // ------------------------------------------------------------------
    logic              s_op;
    logic [5:0]        s_box_index;
    logic signed [31:0] s_ray_origin_x, s_ray_origin_y, s_ray_target_x, s_ray_target_y;
    logic              s_accept;

    assign s_op           = s_tuser[0];
    assign s_box_index    = s_tdata[5:0];
    assign s_ray_origin_x = $signed(s_tdata[165:134]);
    assign s_ray_origin_y = $signed(s_tdata[197:166]);
    assign s_ray_target_x = $signed(s_tdata[229:198]);
    assign s_ray_target_y = $signed(s_tdata[261:230]);
    assign s_accept       = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // Configuration register.
    // ------------------------------------------------------------------
    logic [6:0] active_boxes_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_boxes_reg <= '0;
        end else if (cfg_we) begin
            active_boxes_reg <= cfg_wdata;
        end
    end

    // Number of entries a query searches, capped at the table depth.
    logic [CMPW-1:0] act_ext, n_search;
    assign act_ext  = CMPW'(active_boxes_reg);
    assign n_search = (act_ext > CMPW'(MAX_BOXES)) ? CMPW'(MAX_BOXES) : act_ext;

    // ------------------------------------------------------------------
    // State and datapath registers.
    // ------------------------------------------------------------------
    rbnh_state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, n_reg;
    rbnh_edge_t    k_reg;

    logic signed [31:0] ox_reg, oy_reg;
    logic signed [32:0] dx_reg, dy_reg;
    logic signed [TW-1:0] time_reg [4];
    logic               neg_reg;
    logic signed [TW-1:0] y0_reg, y1_reg, x0_reg, x1_reg, entry_reg, best_reg;
    logic               axes_ok_reg, box_hit_reg, found_reg;
    logic               hit_out_reg;
    logic signed [31:0] time_out_reg, x_out_reg, y_out_reg;

    // ------------------------------------------------------------------
    // Box table.
    // ------------------------------------------------------------------
    logic         mem_we, mem_re;
    logic [127:0] mem_wdata, mem_rdata;

    assign mem_we    = s_accept && (s_op == RBNH_OP_LOAD)
                       && (32'(s_box_index) < 32'(MAX_BOXES));
    assign mem_wdata = s_tdata[133:6];    // {bottom, right, top, left}

    rbnh_box_mem #(
        .DEPTH (MAX_BOXES),
        .AW    (IW)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (IW'(s_box_index)),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (cnt_reg[IW-1:0]),
        .rdata (mem_rdata)
    );

    logic signed [31:0] bx_left, bx_top, bx_right, bx_bottom;
    assign bx_left   = $signed(mem_rdata[31:0]);
    assign bx_top    = $signed(mem_rdata[63:32]);
    assign bx_right  = $signed(mem_rdata[95:64]);
    assign bx_bottom = $signed(mem_rdata[127:96]);

    // ------------------------------------------------------------------
    // Shared serial divide and multiply unit.
    // ------------------------------------------------------------------
    rbnh_alu_ctl_t  alu_ctl;
    rbnh_alu_sts_t  alu_sts;
    logic [32:0]    alu_opa;
    logic [N_W-1:0] alu_opb;
    logic [33:0]    alu_hi;
    logic [N_W-1:0] alu_lo;

    rbnh_alu #(
        .FRAC_BITS (FRAC_BITS)
    ) u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (alu_ctl),
        .opa     (alu_opa),
        .opb     (alu_opb),
        .sts     (alu_sts),
        .res_hi  (alu_hi),
        .res_lo  (alu_lo)
    );

    // ------------------------------------------------------------------
    // Slab step: the edge, origin and direction that this step divides.
    // Steps run top, bottom (y axis), then left, right (x axis).
    // ------------------------------------------------------------------
    logic signed [31:0] st_edge, st_orig;
    logic signed [32:0] st_dir, st_num;
    logic               st_x_axis;
    logic [32:0]        num_abs, dir_abs;

    always_comb begin
        st_x_axis = (k_reg == EDGE_LEFT) || (k_reg == EDGE_RIGHT);
        case (k_reg)
            EDGE_TOP:    st_edge = bx_top;
            EDGE_BOTTOM: st_edge = bx_bottom;
            EDGE_LEFT:   st_edge = bx_left;
            EDGE_RIGHT:  st_edge = bx_right;
            default:     st_edge = bx_left;
        endcase
        st_orig = st_x_axis ? ox_reg : oy_reg;
        st_dir  = st_x_axis ? dx_reg : dy_reg;
        st_num  = {st_edge[31], st_edge} - {st_orig[31], st_orig};
        num_abs = st_num[32] ? (~st_num + 33'd1) : st_num;
        dir_abs = st_dir[32] ? (~st_dir + 33'd1) : st_dir;
    end

    // Magnitude of the best time, multiplier for the hit point.
    logic signed [TW-1:0] best_abs;
    assign best_abs = best_reg[TW-1] ? -best_reg : best_reg;

    logic [32:0] dx_abs, dy_abs;
    assign dx_abs = dx_reg[32] ? (~dx_reg + 33'd1) : dx_reg;
    assign dy_abs = dy_reg[32] ? (~dy_reg + 33'd1) : dy_reg;

    // Signed quotient of the finished divide.
    logic signed [TW-1:0] quot;
    assign quot = neg_reg ? -$signed({1'b0, alu_lo}) : $signed({1'b0, alu_lo});

    // Time saturated to 32 bits.
    function automatic logic signed [31:0] sat_time(input logic signed [TW-1:0] v);
        if (v > T_I32_MAX) begin
            return 32'sh7fffffff;
        end else if (v < T_I32_MIN) begin
            return $signed(32'h80000000);
        end
        return v[31:0];
    endfunction

    // Hit point coordinate: origin plus the product shifted down by the
    // fraction size, its magnitude capped at 2^40, then saturated.
    function automatic logic signed [31:0] hit_coord(input logic [PW-1:0] prod,
                                                     input logic neg,
                                                     input logic signed [31:0] orig);
        logic [66:0]        mag;
        logic               over;
        logic [40:0]        mag_cap;
        logic signed [41:0] sval;
        logic signed [42:0] sum;
        mag     = prod[PW-1:FRAC_BITS];
        over    = (|mag[66:41]) || (mag[40] && (|mag[39:0]));
        mag_cap = over ? {1'b1, 40'd0} : mag[40:0];
        sval    = neg ? -$signed({1'b0, mag_cap}) : $signed({1'b0, mag_cap});
        sum     = {{11{orig[31]}}, orig} + {sval[41], sval};
        if (sum > 43'sh0007fffffff) begin
            return 32'sh7fffffff;
        end else if (sum < -43'sh00080000000) begin
            return $signed(32'h80000000);
        end
        return sum[31:0];
    endfunction

    // ------------------------------------------------------------------
    // Sequencer state register.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and unit control.
    always_comb begin
        state_next   = state_reg;
        alu_ctl      = '{start: 1'b0, mode: ALU_DIV};
        alu_opa      = dir_abs;
        alu_opb      = {num_abs, {FRAC_BITS{1'b0}}};
        mem_re       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept && (s_op == RBNH_OP_QUERY)) begin
                    state_next = (n_search == '0) ? ST_WRAP : ST_READ;
                end
            end
            ST_READ: begin
                mem_re     = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                state_next = ST_STEP;
            end
            ST_STEP: begin
                if (st_dir != '0) begin
                    alu_ctl.start = 1'b1;
                    state_next    = ST_DIV;
                end else if (k_reg == EDGE_RIGHT) begin
                    state_next = ST_ORDER;
                end
            end
            ST_DIV: begin
                if (alu_sts.done) begin
                    state_next = (k_reg == EDGE_RIGHT) ? ST_ORDER : ST_STEP;
                end
            end
            ST_ORDER: begin
                state_next = ST_TEST;
            end
            ST_TEST: begin
                state_next = ST_BEST;
            end
            ST_BEST: begin
                state_next = (cnt_reg + CW'(1) == n_reg) ? ST_WRAP : ST_READ;
            end
            ST_WRAP: begin
                state_next = found_reg ? ST_MULX_GO : ST_OUT;
            end
            ST_MULX_GO: begin
                alu_ctl = '{start: 1'b1, mode: ALU_MUL};
                alu_opa = dx_abs;
                alu_opb = best_abs[N_W-1:0];
                state_next = ST_MULX;
            end
            ST_MULX: begin
                if (alu_sts.done) begin
                    state_next = ST_MULY_GO;
                end
            end
            ST_MULY_GO: begin
                alu_ctl = '{start: 1'b1, mode: ALU_MUL};
                alu_opa = dy_abs;
                alu_opb = best_abs[N_W-1:0];
                state_next = ST_MULY;
            end
            ST_MULY: begin
                if (alu_sts.done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath registers, stepped by the sequencer.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                ox_reg    <= s_ray_origin_x;
                oy_reg    <= s_ray_origin_y;
                dx_reg    <= {s_ray_target_x[31], s_ray_target_x}
                             - {s_ray_origin_x[31], s_ray_origin_x};
                dy_reg    <= {s_ray_target_y[31], s_ray_target_y}
                             - {s_ray_origin_y[31], s_ray_origin_y};
                n_reg     <= CW'(n_search);
                cnt_reg   <= '0;
                found_reg <= 1'b0;
                best_reg  <= '0;
            end
            ST_READ: begin
                k_reg <= EDGE_TOP;
            end
            ST_STEP: begin
                neg_reg <= st_num[32] ^ st_dir[32];
                if (st_dir == '0) begin
                    time_reg[k_reg] <= '0;
                    k_reg           <= rbnh_edge_t'(k_reg + 2'd1);
                end
            end
            ST_DIV: begin
                if (alu_sts.done) begin
                    time_reg[k_reg] <= quot;
                    k_reg           <= rbnh_edge_t'(k_reg + 2'd1);
                end
            end
            ST_ORDER: begin
                // Order each axis; a parallel axis spans [0, far] when the
                // origin lies within its slab and excludes the ray otherwise.
                if (dy_reg == '0) begin
                    y0_reg <= '0;
                    y1_reg <= SLAB_FAR;
                end else if (time_reg[0] > time_reg[1]) begin
                    y0_reg <= time_reg[1];
                    y1_reg <= time_reg[0];
                end else begin
                    y0_reg <= time_reg[0];
                    y1_reg <= time_reg[1];
                end
                if (dx_reg == '0) begin
                    x0_reg <= '0;
                    x1_reg <= SLAB_FAR;
                end else if (time_reg[2] > time_reg[3]) begin
                    x0_reg <= time_reg[3];
                    x1_reg <= time_reg[2];
                end else begin
                    x0_reg <= time_reg[2];
                    x1_reg <= time_reg[3];
                end
                axes_ok_reg <= ((dy_reg != '0)
                                || (bx_top <= oy_reg && oy_reg <= bx_bottom)
                                || (bx_bottom <= oy_reg && oy_reg <= bx_top))
                               && ((dx_reg != '0)
                                || (bx_left <= ox_reg && ox_reg <= bx_right)
                                || (bx_right <= ox_reg && ox_reg <= bx_left));
            end
            ST_TEST: begin
                box_hit_reg <= axes_ok_reg && !(y1_reg < x0_reg) && !(x1_reg < y0_reg)
                               && !x1_reg[TW-1] && !y1_reg[TW-1];
                entry_reg   <= (y0_reg > x0_reg) ? y0_reg : x0_reg;
            end
            ST_BEST: begin
                if (box_hit_reg && (entry_reg < MISS_TIME)
                    && (!found_reg || (entry_reg < best_reg))) begin
                    best_reg  <= entry_reg;
                    found_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + CW'(1);
            end
            ST_WRAP: begin
                hit_out_reg  <= found_reg;
                time_out_reg <= found_reg ? sat_time(best_reg) : '0;
                x_out_reg    <= '0;
                y_out_reg    <= '0;
            end
            ST_MULX_GO: begin
                neg_reg <= dx_reg[32] ^ best_reg[TW-1];
            end
            ST_MULX: begin
                if (alu_sts.done) begin
                    x_out_reg <= hit_coord({alu_hi, alu_lo}, neg_reg, ox_reg);
                end
            end
            ST_MULY_GO: begin
                neg_reg <= dy_reg[32] ^ best_reg[TW-1];
            end
            ST_MULY: begin
                if (alu_sts.done) begin
                    y_out_reg <= hit_coord({alu_hi, alu_lo}, neg_reg, oy_reg);
                end
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Ports.
    // ------------------------------------------------------------------
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {y_out_reg, x_out_reg, time_out_reg};
    assign m_tuser  = hit_out_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    // States that wait on the shared unit and take its result.
    logic alu_wait_st;
    assign alu_wait_st = (state_reg == ST_DIV) || (state_reg == ST_MULX)
                         || (state_reg == ST_MULY);

    `RBNH_ASSERT_IMP(a_ready_idle, s_tready, !m_tvalid && !alu_sts.busy, "ready while busy")
    `RBNH_ASSERT_IMP(a_miss_zero, m_tvalid && !m_tuser[0], m_tdata == '0, "miss not zero")
    `RBNH_ASSERT_NXT(a_start_busy, alu_ctl.start, alu_sts.busy, "unit did not start")
    `RBNH_ASSERT_IMP(a_done_wait, alu_sts.done, alu_wait_st, "unit result unclaimed")

endmodule

[design/rbnh_box_mem.sv]
// ============================================================================
// rbnh_box_mem
// Box table: one write port, one registered read port.
// ============================================================================
module rbnh_box_mem import rbnh_pkg::*; #(
    parameter int DEPTH = RBNH_MAX_BOXES,
    parameter int AW    = 6
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [127:0]  wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [127:0]  rdata
);

    logic [127:0] mem [DEPTH];
    logic [127:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/rbnh_alu.sv]
// ============================================================================
// rbnh_alu
// Shared serial unit: restoring divide or shift-add multiply, one bit a cycle.
// ============================================================================
module rbnh_alu import rbnh_pkg::*; #(
    parameter  int FRAC_BITS = RBNH_FRAC_BITS,
    localparam int N_W       = 33 + FRAC_BITS
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  rbnh_alu_ctl_t ctl,
    input  logic [32:0]   opa,      // divisor or multiplicand magnitude
    input  logic [N_W-1:0] opb,     // dividend or multiplier magnitude
    output rbnh_alu_sts_t sts,
    output logic [33:0]   res_hi,   // remainder or product high part
    output logic [N_W-1:0] res_lo   // quotient or product low part
);

    localparam int SW = $clog2(N_W + 1);

    logic           busy_reg, done_reg;
    logic [SW-1:0]  cnt_reg;
    rbnh_alu_mode_t mode_reg;
    logic [32:0]    a_reg;
    logic [33:0]    hi_reg, hi_next;
    logic [N_W-1:0] lo_reg, lo_next;
    logic [33:0]    trial;
    logic [34:0]    add_x, add_y, sum;
    logic           add_cin;

    // One adder serves both modes: subtract for divide, add for multiply.
    always_comb begin
        trial = {hi_reg[32:0], lo_reg[N_W-1]};
        if (mode_reg == ALU_DIV) begin
            add_x   = {1'b0, trial};
            add_y   = ~{2'b00, a_reg};
            add_cin = 1'b1;
        end else begin
            add_x   = {1'b0, hi_reg};
            add_y   = lo_reg[0] ? {2'b00, a_reg} : 35'd0;
            add_cin = 1'b0;
        end
        sum = add_x + add_y + {34'd0, add_cin};
        if (mode_reg == ALU_DIV) begin
            if (!sum[34]) begin
                hi_next = sum[33:0];
                lo_next = {lo_reg[N_W-2:0], 1'b1};
            end else begin
                hi_next = trial;
                lo_next = {lo_reg[N_W-2:0], 1'b0};
            end
        end else begin
            hi_next = sum[34:1];
            lo_next = {sum[0], lo_reg[N_W-1:1]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (ctl.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + SW'(1);
                if (cnt_reg == SW'(N_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            mode_reg <= ctl.mode;
            a_reg    <= opa;
            hi_reg   <= '0;
            lo_reg   <= opb;
        end else if (busy_reg) begin
            hi_reg <= hi_next;
            lo_reg <= lo_next;
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign res_hi   = hi_reg;
    assign res_lo   = lo_reg;

endmodule
